/* hdl/sidq_pkg.sv */
`timescale 1ns / 1ps

package sidq_pkg;

  localparam int CAPACITY_DEFAULT = 16;
  localparam int VALUE_W          = 32;
  localparam int COUNT_W          = 5;
  localparam int STATUS_W         = 2;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_DELETE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_MISS = 2'd2;

  // shift commands broadcast to every cell
  typedef struct packed {
    logic ins;
    logic del;
  } shift_cmd_t;

endpackage

/* hdl/sidq_cell.sv */
`timescale 1ns / 1ps

module sidq_cell (
  input  logic                                    clk,
  input  sidq_pkg::shift_cmd_t                    cmd,
  input  logic                                    occ,
  input  logic signed [sidq_pkg::VALUE_W-1:0]     value,
  input  logic                                    left_lt,
  input  logic signed [sidq_pkg::VALUE_W-1:0]     left_data,
  input  logic signed [sidq_pkg::VALUE_W-1:0]     right_data,
  output logic                                    lt,
  output logic                                    eq,
  output logic signed [sidq_pkg::VALUE_W-1:0]     data
);

  logic signed [sidq_pkg::VALUE_W-1:0] data_r;
  logic signed [sidq_pkg::VALUE_W-1:0] data_nxt;

  assign lt   = occ && (data_r < value);
  assign eq   = occ && (data_r == value);
  assign data = data_r;

  always_comb begin
    data_nxt = data_r;
    if (cmd.ins && !lt) begin
      data_nxt = left_lt ? value : left_data;
    end else if (cmd.del && !lt) begin
      data_nxt = right_data;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule

/* hdl/sorted_insert_delete_queue_core.sv */
`timescale 1ns / 1ps
// Sorted insert/delete queue.
// Holds up to CAPACITY signed 32-bit values in ascending order, duplicates
// allowed, in a row of cells that compare against the request value in
// parallel and shift one place left or right.
// Input channel: in_tuser = op (0 insert, 1 delete one copy), in_tdata = value.
// Output channel: one result per request: out_tuser[1:0] status (0 done,
// 1 full and insert dropped, 2 not found), [2] empty; out_tdata holds the
// count after the request and the smallest value held (0 when empty).
// The result is registered and valid in the cycle after acceptance.
// Throughput: one request per cycle while the receiver takes each result;
// the whole store updates in the cycle of acceptance, limited by the compare
// across all cells. Reset empties the store (count 0) and drops out_tvalid.
// When the receiver stalls, the held result stays and in_tready drops
// until it is taken; a result taken in the same cycle frees the slot.
module sorted_insert_delete_queue_core #(
  parameter int CAPACITY = sidq_pkg::CAPACITY_DEFAULT
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value
  input  logic        in_tuser,   // [0] op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [4:0] count, [36:5] smallest, [39:37] zero
  output logic [2:0]  out_tuser   // [1:0] status, [2] empty_res
);

  localparam int CW = $clog2(CAPACITY + 1);

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          out_valid_r;
  logic [sidq_pkg::STATUS_W-1:0] status_r, status_nxt;
  logic [sidq_pkg::COUNT_W-1:0]  count_r, count_nxt;
  logic signed [sidq_pkg::VALUE_W-1:0] small_r, small_nxt;
  logic          empty_r, empty_nxt;

  logic signed [sidq_pkg::VALUE_W-1:0] value;
  logic signed [sidq_pkg::VALUE_W-1:0] cell_data [CAPACITY+1];
  logic [CAPACITY:0]   cell_lt;
  logic [CAPACITY-1:0] cell_eq;
  logic [CAPACITY-1:0] occ;
  logic                accept, full, found, ins_ok, del_ok;
  sidq_pkg::shift_cmd_t cmd;

  assign value     = $signed(in_tdata);
  assign accept    = in_tvalid && in_tready;
  assign in_tready = !out_valid_r || out_tready;
  assign full      = (cnt_r == CW'(CAPACITY));
  assign found     = |cell_eq;
  assign ins_ok    = accept && (in_tuser == sidq_pkg::OP_INSERT) && !full;
  assign del_ok    = accept && (in_tuser == sidq_pkg::OP_DELETE) && found;
  assign cmd.ins   = ins_ok;
  assign cmd.del   = del_ok;

  // cell 0 treats its left side as smaller than the value; tail slot feeds zeros
  assign cell_lt[0]          = 1'b1;
  assign cell_data[CAPACITY] = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [sidq_pkg::VALUE_W-1:0] left_d;
    assign occ[i]  = (cnt_r > CW'(i));
    if (i == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_rest
      assign left_d = cell_data[i-1];
    end
    sidq_cell u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .occ        (occ[i]),
      .value      (value),
      .left_lt    (cell_lt[i]),
      .left_data  (left_d),
      .right_data (cell_data[i+1]),
      .lt         (cell_lt[i+1]),
      .eq         (cell_eq[i]),
      .data       (cell_data[i])
    );
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (ins_ok) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (del_ok) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_comb begin
    priority if (ins_ok) begin
      status_nxt = sidq_pkg::ST_DONE;
      small_nxt  = cell_lt[1] ? cell_data[0] : value;
    end else if (del_ok) begin
      status_nxt = sidq_pkg::ST_DONE;
      small_nxt  = cell_lt[1] ? cell_data[0] : cell_data[1];
    end else if (in_tuser == sidq_pkg::OP_INSERT) begin
      status_nxt = sidq_pkg::ST_FULL;
      small_nxt  = cell_data[0];
    end else begin
      status_nxt = sidq_pkg::ST_MISS;
      small_nxt  = cell_data[0];
    end
    empty_nxt = (cnt_nxt == '0);
    if (empty_nxt) begin
      small_nxt = '0;
    end
    count_nxt = sidq_pkg::COUNT_W'(cnt_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
      count_r  <= count_nxt;
      small_r  <= small_nxt;
      empty_r  <= empty_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, small_r, count_r};
  assign out_tuser  = {empty_r, status_r};

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(CAPACITY))
    else $error("fill count beyond capacity");

  a_ins_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_tuser == sidq_pkg::OP_INSERT) && !full) |=>
      (cnt_r == $past(cnt_r) + CW'(1)) && (status_r == sidq_pkg::ST_DONE))
    else $error("insert did not grow the store");

  a_miss_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_tuser == sidq_pkg::OP_DELETE) && !found) |=>
      (cnt_r == $past(cnt_r)) && (status_r == sidq_pkg::ST_MISS))
    else $error("failed delete changed the store");

  a_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_tvalid)
    else $error("accepted request without result");

endmodule

/* sim/sorted_insert_delete_queue_core_test.sv */
`timescale 1ns / 1ps

module sorted_insert_delete_queue_core_test;

  localparam int RANDOM_ITEMS = 1520;
  localparam int CALM_ITEMS   = 200;
  localparam int PHASE_LEN    = 60;
  localparam int CYCLE_LIMIT  = 200000;

  typedef struct packed {
    logic [sidq_pkg::STATUS_W-1:0]       status;
    logic [sidq_pkg::COUNT_W-1:0]        count;
    logic signed [sidq_pkg::VALUE_W-1:0] smallest;
    logic                                empty_res;
  } sidq_result_t;

  class sidq_scoreboard;
    logic signed [sidq_pkg::VALUE_W-1:0] held[$];
    sidq_result_t                        pending[$];
    int                                  capacity;
    int                                  errors;

    function new(int cap);
      capacity = cap;
      errors   = 0;
    endfunction

    // apply one accepted request to the sorted store, queue its result
    function void note_request(logic op, logic signed [sidq_pkg::VALUE_W-1:0] value);
      sidq_result_t r;
      int pos;
      pos = 0;
      while (pos < held.size() && held[pos] < value) pos++;
      if (op == sidq_pkg::OP_INSERT) begin
        if (held.size() >= capacity) begin
          r.status = sidq_pkg::ST_FULL;
        end else begin
          held.insert(pos, value);
          r.status = sidq_pkg::ST_DONE;
        end
      end else if (pos < held.size() && held[pos] == value) begin
        held.delete(pos);
        r.status = sidq_pkg::ST_DONE;
      end else begin
        r.status = sidq_pkg::ST_MISS;
      end
      r.count     = sidq_pkg::COUNT_W'(held.size());
      r.smallest  = (held.size() != 0) ? held[0] : '0;
      r.empty_res = (held.size() == 0);
      pending.push_back(r);
    endfunction

    function void check_result(logic [39:0] data, logic [2:0] user);
      sidq_result_t want;
      if (pending.size() == 0) begin
        $error("result with no request outstanding: tdata=%h tuser=%h", data, user);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (user[1:0] != want.status) begin
        $error("status: expected %0d, actual %0d", want.status, user[1:0]);
        errors++;
      end
      if (data[4:0] != want.count) begin
        $error("count: expected %0d, actual %0d", want.count, data[4:0]);
        errors++;
      end
      if ($signed(data[36:5]) != want.smallest) begin
        $error("smallest: expected %0d, actual %0d", want.smallest, $signed(data[36:5]));
        errors++;
      end
      if (user[2] != want.empty_res) begin
        $error("empty_res: expected %0d, actual %0d", want.empty_res, user[2]);
        errors++;
      end
    endfunction
  endclass

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = '0;
  logic        in_tuser   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic [2:0]  out_tuser;

  logic           calm = 1'b0;
  int             stall_left = 0;
  sidq_scoreboard sb;

  sorted_insert_delete_queue_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // receiver: random stall bursts, steady out_tready once calm is set
  always @(posedge clk) begin
    if (calm) begin
      out_tready <= 1'b1;
    end else if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 4) == 0) begin
      out_tready <= 1'b0;
      stall_left <= $urandom_range(0, 3);
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("FAIL");
    $finish;
  end

  task automatic send_request(input logic op, input logic [31:0] value);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= value;
    do @(posedge clk); while (!in_tready);
    sb.note_request(op, value);
  endtask

  // mostly a small pool so duplicates and hits are common
  function automatic logic [31:0] pick_value();
    unique case ($urandom_range(0, 4))
      0, 1: return $urandom_range(0, 6) - 3;
      2: begin
        if ($urandom_range(0, 1)) return 32'h8000_0000 + $urandom_range(0, 2);
        return 32'h7fff_ffff - $urandom_range(0, 2);
      end
      default: return $urandom();
    endcase
  endfunction

  initial begin
    int bias;
    sb = new(sidq_pkg::CAPACITY_DEFAULT);
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_request(sidq_pkg::OP_DELETE, 32'h0000_0000);   // delete from empty
    send_request(sidq_pkg::OP_INSERT, 32'h7fff_ffff);
    send_request(sidq_pkg::OP_INSERT, 32'h8000_0000);
    send_request(sidq_pkg::OP_INSERT, 32'h0000_0000);
    send_request(sidq_pkg::OP_INSERT, 32'hffff_ffff);
    send_request(sidq_pkg::OP_INSERT, 32'h0000_0000);   // duplicate
    send_request(sidq_pkg::OP_DELETE, 32'h0000_0005);   // absent
    send_request(sidq_pkg::OP_DELETE, 32'h0000_0000);
    send_request(sidq_pkg::OP_DELETE, 32'h0000_0000);
    send_request(sidq_pkg::OP_DELETE, 32'h0000_0000);   // gone now
    for (int i = 0; i < 13; i++) send_request(sidq_pkg::OP_INSERT, i * 1000 - 6000);
    send_request(sidq_pkg::OP_INSERT, 32'h0000_0001);   // full
    send_request(sidq_pkg::OP_INSERT, 32'h8000_0000);   // full, duplicate of min
    send_request(sidq_pkg::OP_DELETE, 32'h8000_0000);
    send_request(sidq_pkg::OP_DELETE, 32'h7fff_ffff);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
      unique case ((n / PHASE_LEN) % 3)
        0: bias = 85;
        1: bias = 15;
        default: bias = 50;
      endcase
      if ($urandom_range(0, 99) < bias)
        send_request(sidq_pkg::OP_INSERT, pick_value());
      else if (sb.held.size() != 0 && $urandom_range(0, 9) < 7)
        send_request(sidq_pkg::OP_DELETE, sb.held[$urandom_range(0, sb.held.size() - 1)]);
      else
        send_request(sidq_pkg::OP_DELETE, pick_value());
    end
    in_tvalid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
